// ===== rtl/avt_pkg.sv =====
// ----------------------------------------------------------------------------
// avt_pkg
// Shared types and constants for the affine vertex transform core: command
// codes, fixed-point widths and the control bundle that steers the lanes.
// ----------------------------------------------------------------------------
package avt_pkg;

	// fixed-point format of matrix and vector words
	localparam int WORD_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 2 * WORD_W;
	// product after the floor shift
	localparam int SH_W      = PROD_W - FRAC_BITS;
	// three shifted products plus the translation word
	localparam int SUM_W     = SH_W + 2;

	localparam int MAT_DEPTH = 16;
	localparam int IDX_W     = $clog2(MAT_DEPTH);
	localparam int ROWS      = 3;

	localparam logic [WORD_W-1:0] ONE_FIX  = WORD_W'(1) << FRAC_BITS;
	localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_POINT = 2'd1,
		CMD_DIR   = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// per-lane stage enables and the point/direction choice
	typedef struct packed {
		logic en1;
		logic en2;
		logic point;
	} lane_ctl_t;

endpackage

// ===== rtl/avt_lane.sv =====
// ----------------------------------------------------------------------------
// avt_lane
// One output row of the transform: three products in the first stage, floor
// shift, exact sum with the translation word and saturation in the second.
// ----------------------------------------------------------------------------
module avt_lane import avt_pkg::*; (
	input  logic                     clk,
	input  lane_ctl_t                ctl,
	input  logic signed [WORD_W-1:0] vx,
	input  logic signed [WORD_W-1:0] vy,
	input  logic signed [WORD_W-1:0] vz,
	input  logic signed [WORD_W-1:0] m_x,
	input  logic signed [WORD_W-1:0] m_y,
	input  logic signed [WORD_W-1:0] m_z,
	input  logic signed [WORD_W-1:0] m_t,
	output logic signed [WORD_W-1:0] sum_s2,
	output logic                     sat_s2
);

	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [WORD_W-1:0] t_s1;
	logic signed [SH_W-1:0]   sh_x, sh_y, sh_z;
	logic signed [SUM_W-1:0]  sum;
	logic                     ovf_pos, ovf_neg;

	// stage 1: full-width products, translation only for a point
	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			px_s1 <= PROD_W'(vx) * PROD_W'(m_x);
			py_s1 <= PROD_W'(vy) * PROD_W'(m_y);
			pz_s1 <= PROD_W'(vz) * PROD_W'(m_z);
			t_s1  <= ctl.point ? m_t : '0;
		end
	end

	// floor shift and exact sum
	always_comb begin
		sh_x = SH_W'(px_s1 >>> FRAC_BITS);
		sh_y = SH_W'(py_s1 >>> FRAC_BITS);
		sh_z = SH_W'(pz_s1 >>> FRAC_BITS);
		sum  = SUM_W'(sh_x) + SUM_W'(sh_y) + SUM_W'(sh_z) + SUM_W'(t_s1);
		// bits above the word must all copy the word's sign bit
		ovf_pos = !sum[SUM_W-1] && (|sum[SUM_W-2:WORD_W-1]);
		ovf_neg =  sum[SUM_W-1] && !(&sum[SUM_W-2:WORD_W-1]);
	end

	// stage 2: clipped word and flag
	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			priority if (ovf_pos) begin
				sum_s2 <= WORD_MAX;
			end else if (ovf_neg) begin
				sum_s2 <= WORD_MIN;
			end else begin
				sum_s2 <= sum[WORD_W-1:0];
			end
			sat_s2 <= ovf_pos || ovf_neg;
		end
	end

endmodule

// ===== rtl/avt_merge.sv =====
// ----------------------------------------------------------------------------
// avt_merge
// Output stage: gathers the three lane results into one beat, merges the
// saturation flags and holds the beat while the consumer stalls.
// ----------------------------------------------------------------------------
module avt_merge import avt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s2,
	input  logic signed [WORD_W-1:0] row_x,
	input  logic signed [WORD_W-1:0] row_y,
	input  logic signed [WORD_W-1:0] row_z,
	input  logic [ROWS-1:0]          row_sat,
	input  logic                     out_stall,
	output logic                     take,
	output logic                     out_valid,
	output logic signed [WORD_W-1:0] out_x,
	output logic signed [WORD_W-1:0] out_y,
	output logic signed [WORD_W-1:0] out_z,
	output logic                     saturated
);

	logic valid_q;

	// register free or being drained this cycle
	assign take      = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= valid_s2;
		end
	end

	// payload, merged flag
	always_ff @(posedge clk) begin
		if (take && valid_s2) begin
			out_x     <= row_x;
			out_y     <= row_y;
			out_z     <= row_z;
			saturated <= |row_sat;
		end
	end

endmodule

// ===== rtl/affine_vertex_transform_core.sv =====
// ----------------------------------------------------------------------------
// affine_vertex_transform_core
// 4x4 column-major Q16.16 vertex transform with saturating outputs.
// ----------------------------------------------------------------------------
// The core accepts one beat per cycle while in_stall is low. An accepted
// transform loads the first stage of 32x32 multipliers (three per row lane,
// three lanes); the second stage then registers the floor shift, sum and
// saturation, and the output register takes the result from there. A load
// beat writes a matrix word at once and gives no result; a transform
// accepted in the next cycle already sees the new word. The matrix resets
// to the identity. Command 3 is accepted and dropped.
// ----------------------------------------------------------------------------
module affine_vertex_transform_core import avt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               command,
	input  logic [IDX_W-1:0]         element_index,
	input  logic signed [WORD_W-1:0] element_value,
	input  logic signed [WORD_W-1:0] in_x,
	input  logic signed [WORD_W-1:0] in_y,
	input  logic signed [WORD_W-1:0] in_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] out_x,
	output logic signed [WORD_W-1:0] out_y,
	output logic signed [WORD_W-1:0] out_z,
	output logic                     saturated
);

	logic signed [WORD_W-1:0] mat_q [MAT_DEPTH];
	logic                     v1_q, v2_q;
	logic                     rdy1, rdy2, rdy3;
	logic                     in_beat, is_load, is_xform;
	cmd_t                     cmd;
	lane_ctl_t                ctl;
	logic signed [WORD_W-1:0] row_sum [ROWS];
	logic [ROWS-1:0]          row_sat;

	// command decode
	always_comb begin
		cmd      = cmd_t'(command);
		in_beat  = in_valid && !in_stall;
		is_load  = in_beat && (cmd == CMD_LOAD);
		is_xform = in_beat && ((cmd == CMD_POINT) || (cmd == CMD_DIR));
	end

	// stage advance chain
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign in_stall = !rdy1;

	assign ctl.en1   = rdy1;
	assign ctl.en2   = rdy2;
	assign ctl.point = (cmd == CMD_POINT);

	// matrix words, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_DEPTH; i++) begin
				mat_q[i] <= ((i % 5) == 0) ? ONE_FIX : '0;
			end
		end else if (is_load) begin
			mat_q[element_index] <= element_value;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= is_xform;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
		end
	end

	// one lane per output row
	for (genvar r = 0; r < ROWS; r++) begin : g_lane
		avt_lane u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.vx     (in_x),
			.vy     (in_y),
			.vz     (in_z),
			.m_x    (mat_q[r]),
			.m_y    (mat_q[4 + r]),
			.m_z    (mat_q[8 + r]),
			.m_t    (mat_q[12 + r]),
			.sum_s2 (row_sum[r]),
			.sat_s2 (row_sat[r])
		);
	end

	avt_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (v2_q),
		.row_x     (row_sum[0]),
		.row_y     (row_sum[1]),
		.row_z     (row_sum[2]),
		.row_sat   (row_sat),
		.out_stall (out_stall),
		.take      (rdy3),
		.out_valid (out_valid),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.saturated (saturated)
	);

	// a flagged beat carries at least one clipped component
	a_sat_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(out_x == WORD_MAX) || (out_x == WORD_MIN) ||
			(out_y == WORD_MAX) || (out_y == WORD_MIN) ||
			(out_z == WORD_MAX) || (out_z == WORD_MIN))
		else $error("saturated flag without a clipped component");

	// a load lands in the matrix by the next edge
	a_load_written: assert property (@(posedge clk) disable iff (!arst_n)
		is_load |=> mat_q[$past(element_index)] == $past(element_value))
		else $error("matrix word not written by load beat");

	// an accepted transform occupies the first stage
	a_xform_enters: assert property (@(posedge clk) disable iff (!arst_n)
		is_xform |=> v1_q)
		else $error("transform beat lost at pipeline entry");

	// a load never creates a pipeline item
	a_load_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && (cmd == CMD_LOAD) |=> !v1_q)
		else $error("load beat entered the pipeline");

endmodule

// ===== test/affine_vertex_transform_core_test.sv =====
// ----------------------------------------------------------------------------
// affine_vertex_transform_core_test
// Self-checking bench for the vertex transform core. A short directed script
// walks the identity after reset, the extreme words, saturation, unused
// matrix words and the ignored command. Then a long random mix of matrix
// loads, points and directions follows. A local fixed-point model of the
// matrix predicts every transform, and each output beat is checked against
// the oldest prediction. Both sides of the core pause at random, and the
// output side holds off once for a long stretch so that the core backs up.
// ----------------------------------------------------------------------------
module affine_vertex_transform_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import avt_pkg::*;

	localparam int RANDOM_BEATS = 1800;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int REPORT_CAP   = 100;

	localparam logic signed [WORD_W-1:0] FIX_ONE   = ONE_FIX;
	localparam logic signed [WORD_W-1:0] FIX_TWO   = ONE_FIX * 2;
	localparam logic signed [WORD_W-1:0] FIX_THREE = ONE_FIX * 3;
	localparam logic signed [WORD_W-1:0] FIX_FIVE  = ONE_FIX * 5;
	localparam logic signed [WORD_W-1:0] FIX_SIX   = ONE_FIX * 6;
	localparam logic signed [WORD_W-1:0] FIX_MAX   = WORD_MAX;
	localparam logic signed [WORD_W-1:0] FIX_MIN   = WORD_MIN;
	localparam longint LANE_HIGH = longint'(2147483647);
	localparam longint LANE_LOW  = -longint'(2147483647) - 1;

	typedef struct {
		logic signed [WORD_W-1:0] x;
		logic signed [WORD_W-1:0] y;
		logic signed [WORD_W-1:0] z;
		logic                     sat;
	} vertex_out_t;

	typedef struct {
		cmd_t                     op;
		logic [IDX_W-1:0]         idx;
		logic signed [WORD_W-1:0] val;
		logic signed [WORD_W-1:0] x;
		logic signed [WORD_W-1:0] y;
		logic signed [WORD_W-1:0] z;
		bit                       typed;
		vertex_out_t              want;
	} beat_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               command;
	logic [IDX_W-1:0]         element_index;
	logic signed [WORD_W-1:0] element_value;
	logic signed [WORD_W-1:0] in_x;
	logic signed [WORD_W-1:0] in_y;
	logic signed [WORD_W-1:0] in_z;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [WORD_W-1:0] out_x;
	logic signed [WORD_W-1:0] out_y;
	logic signed [WORD_W-1:0] out_z;
	logic                     saturated;

	// local copy of the transform matrix and pending results
	logic signed [WORD_W-1:0] xform_mat [MAT_DEPTH];
	vertex_out_t              vertex_expect [$];
	beat_t                    directed_rows [$];
	int                       mismatches = 0;
	int                       quiet_cycles = 0;
	bit                       hold_due = 1'b0;

	affine_vertex_transform_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.element_index (element_index),
		.element_value (element_value),
		.in_x          (in_x),
		.in_y          (in_y),
		.in_z          (in_z),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.saturated     (saturated)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// matrix times vector: floor-shifted products, exact sum, saturate per lane
	function automatic vertex_out_t transform_vertex(cmd_t op, logic signed [WORD_W-1:0] vx,
			logic signed [WORD_W-1:0] vy, logic signed [WORD_W-1:0] vz);
		vertex_out_t res;
		longint      vec [3];
		longint      acc;
		longint      part;
		logic signed [WORD_W-1:0] lane [3];
		vec[0] = longint'(vx);
		vec[1] = longint'(vy);
		vec[2] = longint'(vz);
		res.sat = 1'b0;
		for (int row = 0; row < ROWS; row++) begin
			acc = 0;
			for (int col = 0; col < 3; col++) begin
				part = vec[col] * longint'(xform_mat[col * 4 + row]);
				acc += part >>> FRAC_BITS;
			end
			if (op == CMD_POINT)
				acc += longint'(xform_mat[12 + row]);
			if (acc > LANE_HIGH) begin
				acc = LANE_HIGH;
				res.sat = 1'b1;
			end else if (acc < LANE_LOW) begin
				acc = LANE_LOW;
				res.sat = 1'b1;
			end
			lane[row] = acc[WORD_W-1:0];
		end
		res.x = lane[0];
		res.y = lane[1];
		res.z = lane[2];
		return res;
	endfunction

	// update the matrix copy and queue the result an accepted beat causes
	function automatic void post_beat(beat_t b);
		case (b.op)
			CMD_LOAD: begin
				xform_mat[b.idx] = b.val;
			end
			CMD_POINT, CMD_DIR: begin
				if (b.typed)
					vertex_expect.push_back(b.want);
				else
					vertex_expect.push_back(transform_vertex(b.op, b.x, b.y, b.z));
			end
			default: ;
		endcase
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// matrix words: mostly modest gains, some extremes, some raw
	function automatic logic signed [WORD_W-1:0] matrix_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 8 << FRAC_BITS) - (4 << FRAC_BITS);
		if (r < 85) begin
			case ($urandom_range(0, 6))
				0: return FIX_MAX;
				1: return FIX_MIN;
				2: return 0;
				3: return -1;
				4: return 1;
				5: return FIX_ONE;
				default: return -FIX_ONE;
			endcase
		end
		return $urandom;
	endfunction

	// vector words: mostly within +-1024.0, some extremes, some raw
	function automatic logic signed [WORD_W-1:0] vector_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 1 << 27) - (1 << 26);
		if (r < 75) begin
			case ($urandom_range(0, 4))
				0: return FIX_MAX;
				1: return FIX_MIN;
				2: return 0;
				3: return -1;
				default: return FIX_ONE;
			endcase
		end
		return $urandom;
	endfunction

	function automatic beat_t random_beat();
		beat_t b;
		int    r;
		r = $urandom_range(0, 99);
		if (r < 14)
			b.op = CMD_LOAD;
		else if (r < 17)
			b.op = CMD_NOP;
		else if (r < 60)
			b.op = CMD_POINT;
		else
			b.op = CMD_DIR;
		b.idx = IDX_W'($urandom_range(0, MAT_DEPTH - 1));
		b.val = (b.op == CMD_LOAD) ? matrix_word() : $urandom;
		b.x = vector_word();
		b.y = vector_word();
		b.z = vector_word();
		b.typed = 1'b0;
		b.want = '{0, 0, 0, 1'b0};
		return b;
	endfunction

	// present one beat and wait for the core to take it
	task automatic offer_beat(beat_t b);
		in_valid <= 1'b1;
		command <= b.op;
		element_index <= b.idx;
		element_value <= b.val;
		in_x <= b.x;
		in_y <= b.y;
		in_z <= b.z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		post_beat(b);
	endtask

	// sender pause after a beat, with stretches of back-to-back beats
	task automatic sender_pause(ref int calm_left);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 49) == 0)
				calm_left = $urandom_range(20, 60);
			gap = idle_len();
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// directed script: typed results only where they follow at a glance
	function automatic void build_script();
		vertex_out_t none;
		none = '{0, 0, 0, 1'b0};
		// identity after reset
		directed_rows.push_back('{CMD_POINT, 4'd0, 0, FIX_ONE, FIX_TWO, FIX_THREE, 1'b1,
			'{FIX_ONE, FIX_TWO, FIX_THREE, 1'b0}});
		directed_rows.push_back('{CMD_DIR, 4'd0, 0, FIX_MAX, FIX_MIN, -1, 1'b1,
			'{FIX_MAX, FIX_MIN, -1, 1'b0}});
		// unused command is dropped
		directed_rows.push_back('{CMD_NOP, 4'd15, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX, 1'b0, none});
		// transform ignores the load fields
		directed_rows.push_back('{CMD_POINT, 4'd15, FIX_MAX, -FIX_ONE, 0, FIX_ONE, 1'b1,
			'{-FIX_ONE, 0, FIX_ONE, 1'b0}});
		// translation applies to points only; load ignores the vector
		directed_rows.push_back('{CMD_LOAD, 4'd12, FIX_FIVE, FIX_MAX, FIX_MIN, -1, 1'b0, none});
		directed_rows.push_back('{CMD_POINT, 4'd0, 0, FIX_ONE, 0, 0, 1'b1,
			'{FIX_SIX, 0, 0, 1'b0}});
		directed_rows.push_back('{CMD_DIR, 4'd0, 0, FIX_ONE, 0, 0, 1'b1,
			'{FIX_ONE, 0, 0, 1'b0}});
		// saturation at both ends
		directed_rows.push_back('{CMD_LOAD, 4'd0, FIX_MAX, 0, 0, 0, 1'b0, none});
		directed_rows.push_back('{CMD_POINT, 4'd0, 0, FIX_MAX, 0, 0, 1'b1,
			'{FIX_MAX, 0, 0, 1'b1}});
		directed_rows.push_back('{CMD_POINT, 4'd0, 0, FIX_MIN, 0, 0, 1'b1,
			'{FIX_MIN, 0, 0, 1'b1}});
		// bottom row words never reach a result
		directed_rows.push_back('{CMD_LOAD, 4'd3, FIX_MIN, 0, 0, 0, 1'b0, none});
		directed_rows.push_back('{CMD_LOAD, 4'd7, FIX_MAX, 0, 0, 0, 1'b0, none});
		directed_rows.push_back('{CMD_LOAD, 4'd11, -1, 0, 0, 0, 1'b0, none});
		directed_rows.push_back('{CMD_LOAD, 4'd15, 0, 0, 0, 0, 1'b0, none});
		directed_rows.push_back('{CMD_DIR, 4'd0, 0, FIX_ONE, FIX_ONE, FIX_ONE, 1'b0, none});
		// floor shift of a tiny negative product
		directed_rows.push_back('{CMD_LOAD, 4'd0, 1, 0, 0, 0, 1'b0, none});
		directed_rows.push_back('{CMD_DIR, 4'd0, 0, -1, 0, 0, 1'b0, none});
		// extreme translation words
		directed_rows.push_back('{CMD_LOAD, 4'd13, FIX_MIN, 0, 0, 0, 1'b0, none});
		directed_rows.push_back('{CMD_LOAD, 4'd14, FIX_MAX, 0, 0, 0, 1'b0, none});
		directed_rows.push_back('{CMD_POINT, 4'd0, 0, 0, 0, 0, 1'b1,
			'{FIX_FIVE, FIX_MIN, FIX_MAX, 1'b0}});
		directed_rows.push_back('{CMD_POINT, 4'd0, 0, 0, 0, FIX_ONE, 1'b0, none});
		// extreme cross terms
		directed_rows.push_back('{CMD_LOAD, 4'd4, FIX_MIN, 0, 0, 0, 1'b0, none});
		directed_rows.push_back('{CMD_LOAD, 4'd9, FIX_MIN, 0, 0, 0, 1'b0, none});
		directed_rows.push_back('{CMD_DIR, 4'd0, 0, FIX_MIN, FIX_MIN, FIX_MIN, 1'b0, none});
		directed_rows.push_back('{CMD_POINT, 4'd0, 0, FIX_MAX, FIX_MAX, FIX_MAX, 1'b0, none});
	endfunction

	// sender: reset, directed script, random beats, drain
	initial begin : source_side
		int    calm_left;
		int    sent;
		beat_t b;
		calm_left = 0;
		sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_NOP;
		element_index <= '0;
		element_value <= '0;
		in_x <= '0;
		in_y <= '0;
		in_z <= '0;
		out_stall <= 1'b0;
		foreach (xform_mat[i])
			xform_mat[i] = '0;
		xform_mat[0] = ONE_FIX;
		xform_mat[5] = ONE_FIX;
		xform_mat[10] = ONE_FIX;
		xform_mat[15] = ONE_FIX;
		build_script();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer_beat(directed_rows[i]);
			sender_pause(calm_left);
		end

		while (sent < RANDOM_BEATS) begin
			b = random_beat();
			offer_beat(b);
			if (b.op != CMD_NOP)
				sent++;
			// one long output hold-off while beats keep coming
			if (sent == 600)
				hold_due = 1'b1;
			sender_pause(calm_left);
		end
		in_valid <= 1'b0;

		while (vertex_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[affine_vertex_transform_core] OK");
		else
			$display("[affine_vertex_transform_core] ERROR");
		$finish;
	end

	// receiver pacing, including the long hold-off
	initial begin : sink_side
		int stall_len;
		int ready_len;
		int calm_left;
		calm_left = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_due) begin
				hold_due = 1'b0;
				stall_len = HOLD_CYCLES;
			end else if (calm_left > 0) begin
				calm_left--;
				stall_len = 0;
			end else begin
				if ($urandom_range(0, 29) == 0)
					calm_left = $urandom_range(5, 15);
				stall_len = idle_len();
			end
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			ready_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			repeat (ready_len) @(posedge clk);
		end
	end

	// compare each output beat with the oldest prediction
	always @(posedge clk) begin
		vertex_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (vertex_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$error("unexpected output beat: out_x %0d out_y %0d out_z %0d",
						out_x, out_y, out_z);
			end else begin
				want = vertex_expect.pop_front();
				if (out_x !== want.x) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$error("out_x: expected %0d, got %0d", want.x, out_x);
				end
				if (out_y !== want.y) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$error("out_y: expected %0d, got %0d", want.y, out_y);
				end
				if (out_z !== want.z) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$error("out_z: expected %0d, got %0d", want.z, out_z);
				end
				if (saturated !== want.sat) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$error("saturated: expected %0d, got %0d", want.sat, saturated);
				end
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[affine_vertex_transform_core] ERROR");
			$finish;
		end
	end

endmodule

// ===== files.f =====
rtl/avt_pkg.sv
rtl/avt_lane.sv
rtl/avt_merge.sv
rtl/affine_vertex_transform_core.sv
test/affine_vertex_transform_core_test.sv
